// ----- rtl/core/stnv_pkg.sv -----
// Shared types and constants for the sorted table nearest value block.
`timescale 1ns / 1ps

package stnv_pkg;

  localparam int DATA_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Per-cell compare results: target vs. own entry, and pair decision with upper neighbor.
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
    logic up;
  } cell_flags_t;

  typedef struct packed {
    logic in_ready;
    logic result_load;
  } ctl_t;

endpackage

// ----- rtl/core/stnv_cell.sv -----
// One table cell: holds an entry, its difference to the target and the pair decision.
`timescale 1ns / 1ps

module stnv_cell import stnv_pkg::*; (
  input  logic                     clk,
  input  logic                     we,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     diff_en,
  input  logic signed [DATA_W-1:0] target,
  input  logic signed [DIFF_W-1:0] nbr_diff,
  output logic signed [DATA_W-1:0] entry,
  output logic signed [DIFF_W-1:0] diff,
  output cell_flags_t              flags
);

  logic              up;
  logic [DIFF_W:0]   pair_sum;

  // (t - e[i]) + (t - e[i+1]) >= 0  <=>  t - e[i] >= e[i+1] - t
  assign pair_sum = {diff[DIFF_W-1], diff} + {nbr_diff[DIFF_W-1], nbr_diff};

  always_ff @(posedge clk) begin
    if (we) begin
      entry <= wdata;
    end
    if (diff_en) begin
      diff <= {target[DATA_W-1], target} - {entry[DATA_W-1], entry};
    end
    up <= ~pair_sum[DIFF_W];
  end

  always_comb begin
    flags.lt = diff[DIFF_W-1];
    flags.eq = (diff == '0);
    flags.gt = ~diff[DIFF_W-1] && (diff != '0);
    flags.up = up;
  end

endmodule

// ----- rtl/core/stnv_ctrl.sv -----
// Search sequencer: walks the binary search over the cell compare flags.
`timescale 1ns / 1ps

module stnv_ctrl import stnv_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              func,
  input  logic [COUNT_W-1:0]                entry_count,
  input  logic                              out_stall,
  input  cell_flags_t                       flags [TABLE_DEPTH],
  output ctl_t                              ctl,
  output logic [$clog2(TABLE_DEPTH)-1:0]    res_idx
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] sel;
  logic             pair;

  logic [CNT_W-1:0] n_c;
  logic [IDX_W-1:0] last_c;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_c;
  logic [IDX_W-1:0] mid_dn;
  logic [CNT_W:0]   mid_nx;
  logic             nx_ok;

  always_comb begin
    if (entry_count == '0) begin
      n_c = CNT_W'(1);
    end else if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_c = CNT_W'(TABLE_DEPTH);
    end else begin
      n_c = CNT_W'(entry_count);
    end
    last_c  = IDX_W'(n_c - CNT_W'(1));
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid_c   = IDX_W'(mid_sum >> 1);
    mid_dn  = mid_c - IDX_W'(1);
    mid_nx  = (CNT_W + 1)'(mid_c) + (CNT_W + 1)'(1);
    nx_ok   = mid_nx < {1'b0, n_c};
  end

  assign res_idx         = pair ? sel + IDX_W'(flags[sel].up) : sel;
  assign ctl.in_ready    = (state == ST_IDLE);
  assign ctl.result_load = (state == ST_FIN) && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lo    <= '0;
      hi    <= '0;
      mid   <= '0;
      sel   <= '0;
      pair  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && func == FUNC_QUERY) begin
            state <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          pair <= 1'b0;
          if (flags[0].lt || flags[0].eq) begin
            sel   <= '0;
            state <= ST_FIN;
          end else if (flags[last_c].gt || flags[last_c].eq) begin
            sel   <= last_c;
            state <= ST_FIN;
          end else begin
            lo    <= '0;
            hi    <= n_c;
            mid   <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (lo < hi) begin
            mid <= mid_c;
            if (flags[mid_c].eq) begin
              sel   <= mid_c;
              state <= ST_FIN;
            end else if (flags[mid_c].lt) begin
              if (mid_c != '0 && flags[mid_dn].gt) begin
                sel   <= mid_dn;
                pair  <= 1'b1;
                state <= ST_FIN;
              end else begin
                hi <= CNT_W'(mid_c);
              end
            end else begin
              if (nx_ok && flags[IDX_W'(mid_nx)].lt) begin
                sel   <= mid_c;
                pair  <= 1'b1;
                state <= ST_FIN;
              end else begin
                lo <= CNT_W'(mid_nx);
              end
            end
          end else begin
            sel   <= mid;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sorted_table_nearest_value.sv -----
// Top level: sorted table of signed entries answering nearest-value queries.
// Flow: a query's difference is registered in every cell, then the edge check, the search walk
//   (skipped for targets at or beyond a table end) and the result load run in turn.
// No new transaction is taken until the query's result is loaded, which waits out a pending result;
//   a load transaction gives no result and leaves the input ready.
// Reset: entry_count returns to 16, handshake state clears; table contents are undefined.
`timescale 1ns / 1ps

module sorted_table_nearest_value import stnv_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic [INDEX_W-1:0]       entry_index,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] closest_value,
  input  logic                     cfg_we,
  input  logic [COUNT_W-1:0]       cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [COUNT_W-1:0]       entry_count;
  logic                     in_fire;
  logic                     load_go;
  logic                     diff_en;
  logic                     out_stall;
  ctl_t                     ctl;
  logic [IDX_W-1:0]         res_idx;
  cell_flags_t              flags   [TABLE_DEPTH];
  logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
  logic signed [DIFF_W-1:0] diffs   [TABLE_DEPTH + 1];

  assign in_ready  = ctl.in_ready;
  assign in_fire   = in_valid && in_ready;
  assign load_go   = in_fire && (func == FUNC_LOAD);
  assign diff_en   = in_fire && (func == FUNC_QUERY);
  assign out_stall = out_valid && !out_ready;
  assign diffs[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    stnv_cell u_cell (
      .clk      (clk),
      .we       (load_go && ({28'd0, entry_index} == 32'(i))),
      .wdata    (operand_value),
      .diff_en  (diff_en),
      .target   (operand_value),
      .nbr_diff (diffs[i + 1]),
      .entry    (entries[i]),
      .diff     (diffs[i]),
      .flags    (flags[i])
    );
  end

  stnv_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .func        (func),
    .entry_count (entry_count),
    .out_stall   (out_stall),
    .flags       (flags),
    .ctl         (ctl),
    .res_idx     (res_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
      if (ctl.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      closest_value <= entries[res_idx];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.result_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transaction");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_QUERY) |=> !in_ready)
    else $error("input ready right after a query transaction");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.result_load))
    else $error("out_valid rose without a result load");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the sorted table nearest value block.
`timescale 1ns / 1ps

module testbench;
  import stnv_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int CLK_PERIOD   = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 16;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 400;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     func = FUNC_LOAD;
  logic [INDEX_W-1:0]       entry_index = '0;
  logic signed [DATA_W-1:0] operand_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] closest_value;
  logic                     cfg_we = 1'b0;
  logic [COUNT_W-1:0]       cfg_wdata = '0;

  logic signed [DATA_W-1:0] entry_mirror [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_mirror = COUNT_RESET;
  logic signed [DATA_W-1:0] expected_closest [$];
  logic signed [DATA_W-1:0] want;

  int error_count  = 0;
  int items_sent   = 0;
  int src_idle_pct = 34;
  int snk_idle_pct = 60;
  int hold_request = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  sorted_table_nearest_value #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .entry_index  (entry_index),
    .operand_value(operand_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .closest_value(closest_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int active_entries();
    if (count_mirror == 0) return 1;
    if (count_mirror > TABLE_DEPTH) return TABLE_DEPTH;
    return count_mirror;
  endfunction

  // tie goes to the upper neighbor; 33-bit differences
  function automatic logic signed [DATA_W-1:0] nearer_neighbor(
    input logic signed [DATA_W-1:0] lower,
    input logic signed [DATA_W-1:0] upper,
    input logic signed [DATA_W-1:0] target
  );
    logic signed [DIFF_W-1:0] t, l, u;
    t = target;
    l = lower;
    u = upper;
    return ((t - l) >= (u - t)) ? upper : lower;
  endfunction

  function automatic logic signed [DATA_W-1:0] nearest_entry(
    input logic signed [DATA_W-1:0] target
  );
    int n, lo, hi, mid;
    n = active_entries();
    if (target <= entry_mirror[0]) return entry_mirror[0];
    if (target >= entry_mirror[n-1]) return entry_mirror[n-1];
    lo = 0;
    hi = n;
    mid = 0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (entry_mirror[mid] == target) return entry_mirror[mid];
      if (target < entry_mirror[mid]) begin
        if (mid > 0) begin
          if (target > entry_mirror[mid-1])
            return nearer_neighbor(entry_mirror[mid-1], entry_mirror[mid], target);
        end
        hi = mid;
      end else begin
        if (mid + 1 < n) begin
          if (target < entry_mirror[mid+1])
            return nearer_neighbor(entry_mirror[mid], entry_mirror[mid+1], target);
        end
        lo = mid + 1;
      end
    end
    return entry_mirror[mid];
  endfunction

  task automatic send_item(
    input logic                     f,
    input logic [INDEX_W-1:0]       idx,
    input logic signed [DATA_W-1:0] v
  );
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    entry_index   <= idx;
    operand_value <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (f == FUNC_LOAD)
      entry_mirror[idx] = v;
    else
      expected_closest.push_back(nearest_entry(v));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_closest.size() != 0) @(posedge clk);
  endtask

  task automatic set_entry_count(input logic [COUNT_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_mirror = v;
  endtask

  task automatic test_directed_table();
    logic signed [DATA_W-1:0] vals [TABLE_DEPTH];
    vals = '{VAL_MIN, -1000000000, -5000, -100, -10, -1, 0, 0,
             1, 7, 10, 100, 5000, 1000000000, 2147483646, VAL_MAX};
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(FUNC_LOAD, INDEX_W'(i), vals[i]);
    send_item(FUNC_QUERY, 4'hf, VAL_MIN);
    send_item(FUNC_QUERY, 4'h0, VAL_MAX);
    send_item(FUNC_QUERY, 4'h5, 7);
    send_item(FUNC_QUERY, 4'ha, 55);     // tie between 10 and 100
    send_item(FUNC_QUERY, 4'h3, 54);
    send_item(FUNC_QUERY, 4'hc, 0);      // duplicate entries
    send_item(FUNC_QUERY, 4'h9, 2147483645);
  endtask

  task automatic test_directed_counts();
    set_entry_count(5'd0);
    send_item(FUNC_QUERY, 4'h1, 12345);
    set_entry_count(5'd31);
    send_item(FUNC_QUERY, 4'h2, 2147483000);
    set_entry_count(5'd1);
    send_item(FUNC_QUERY, 4'h4, VAL_MAX);
    set_entry_count(5'd2);
    send_item(FUNC_QUERY, 4'h8, -1500000000);
  endtask

  // output held off while queries are still offered, then a full drain
  task automatic test_backpressure();
    set_entry_count(COUNT_RESET);
    hold_request = HOLD_CYCLES;
    repeat (24) send_item(FUNC_QUERY, INDEX_W'($urandom_range(15)), $urandom);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int quota);
    int start, n, k, idx, base;
    bit up;
    int vals [$];
    logic [COUNT_W-1:0] cnt;
    logic signed [DATA_W-1:0] t;
    logic signed [DIFF_W-1:0] pair_sum;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(9))
          0: cnt = 5'd0;
          1: cnt = COUNT_W'($urandom_range(17, 31));
          2, 3: cnt = COUNT_RESET;
          default: cnt = COUNT_W'($urandom_range(1, 16));
        endcase
        set_entry_count(cnt);
      end
      n = active_entries();
      if ($urandom_range(9) == 0) begin
        // stray loads, order of the table not kept
        repeat ($urandom_range(1, 3))
          send_item(FUNC_LOAD, INDEX_W'($urandom_range(15)), $urandom);
      end else begin
        vals.delete();
        case ($urandom_range(2))
          0: begin
            for (int i = 0; i < n; i++) vals.push_back($urandom);
            vals.sort();
          end
          1: begin
            base = int'($urandom) >>> 4;
            for (int i = 0; i < n; i++) begin
              base += $urandom_range(0, 6);
              vals.push_back(base);
            end
          end
          default: begin
            for (int i = 0; i < n; i++) vals.push_back($urandom);
            vals.sort();
            vals[0] = VAL_MIN;
            vals[n-1] = VAL_MAX;
          end
        endcase
        up = $urandom_range(1);
        for (int i = 0; i < n; i++) begin
          idx = up ? i : n - 1 - i;
          send_item(FUNC_LOAD, INDEX_W'(idx), vals[idx]);
        end
      end
      repeat ($urandom_range(4, 16)) begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(7))
          0: t = entry_mirror[k];
          1: t = entry_mirror[k] + $urandom_range(1, 3);
          2: t = entry_mirror[k] - $urandom_range(1, 3);
          3: begin
            if (k + 1 < n) begin
              pair_sum = entry_mirror[k];
              pair_sum = pair_sum + entry_mirror[k+1];
              t = pair_sum[DIFF_W-1:1] + (pair_sum[0] & $urandom_range(1));
            end else begin
              t = entry_mirror[k];
            end
          end
          4: t = $urandom_range(1) ? VAL_MIN : VAL_MAX;
          default: t = $urandom;
        endcase
        send_item(FUNC_QUERY, INDEX_W'($urandom_range(15)), t);
      end
    end
  endtask

  task automatic finish_checks();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_closest.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_closest.size()));
  endtask

  // result sink with random stalls and a requested hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_closest.size() == 0) begin
        report_mismatch($sformatf("unexpected result closest_value=%0d", closest_value));
      end else begin
        want = expected_closest.pop_front();
        if (closest_value !== want)
          report_mismatch($sformatf("closest_value got %0d expected %0d",
                                    closest_value, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) entry_mirror[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_table();
    test_directed_counts();
    test_backpressure();
    test_random_traffic(200);
    src_idle_pct = 60;
    snk_idle_pct = 34;
    test_random_traffic(200);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(200);
    finish_checks();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/stnv_pkg.sv
rtl/core/stnv_cell.sv
rtl/core/stnv_ctrl.sv
rtl/core/sorted_table_nearest_value.sv
verif/testbench.sv
